/* design/sbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared sizes, codes and request structs for the sparse bit matrix unit.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // Storage sizes
  localparam int MAX_COLUMNS = 64;
  localparam int COLUMN_BITS = 256;
  localparam int DENSE_BITS  = 1024;
  localparam int DENSE_WORD  = 32;
  localparam int DENSE_ROWS  = (DENSE_BITS + DENSE_WORD - 1) / DENSE_WORD;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 9;
  localparam int LIMIT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int USED_W      = $clog2(MAX_COLUMNS + 1);
  localparam int BIT_IDX_W   = (COLUMN_BITS > 1) ? $clog2(COLUMN_BITS) : 1;
  localparam int DENSE_ROW_W = (DENSE_ROWS > 1) ? $clog2(DENSE_ROWS) : 1;
  localparam int DENSE_BIT_W = $clog2(DENSE_WORD);
  localparam int DENSE_IDX_W = DENSE_ROW_W + DENSE_BIT_W;
  localparam int CMP_W       = POS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_WIPE
  } state_t;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = 1'd1;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic                 alloc;
    logic [COL_IDX_W-1:0] addr;
    logic [BIT_IDX_W-1:0] bit_sel;
    logic                 bit_val;
  } col_req_t;

  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic                   wipe;
    logic [DENSE_ROW_W-1:0] row;
    logic [DENSE_BIT_W-1:0] bit_sel;
    logic                   bit_val;
  } dense_req_t;

endpackage

/* design/sbm_key_cam.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_key_cam
// Column key table: parallel compare into a registered match vector,
// allocation in order of use, and the count of columns in use.
// ----------------------------------------------------------------------------
module sbm_key_cam
  import sbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lookup_en,
  input  logic [KEY_W-1:0]     lookup_key,
  input  logic                 clear,
  input  logic                 alloc_en,
  input  logic [KEY_W-1:0]     alloc_key,
  output logic                 hit,
  output logic [COL_IDX_W-1:0] hit_idx,
  output logic [COL_IDX_W-1:0] alloc_idx,
  output logic                 full
);

  logic [KEY_W-1:0]       keys [MAX_COLUMNS];
  logic [USED_W-1:0]      used;
  logic [MAX_COLUMNS-1:0] match_q;
  logic [MAX_COLUMNS-1:0] match_next;

  // Entries at or above the fill count are never compared.
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      match_next[i] = (USED_W'(i) < used) && (keys[i] == lookup_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= '0;
      used    <= '0;
    end else begin
      if (lookup_en) begin
        match_q <= match_next;
      end
      if (clear) begin
        used <= '0;
      end else if (alloc_en) begin
        used <= used + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_en) begin
      keys[alloc_idx] <= alloc_key;
    end
  end

  // Keys are unique, so at most one match: an OR of indices encodes it.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      hit_idx = hit_idx | (match_q[i] ? COL_IDX_W'(i) : '0);
    end
  end

  assign hit       = |match_q;
  assign full      = (used >= USED_W'(MAX_COLUMNS));
  assign alloc_idx = used[COL_IDX_W-1:0];

  a_unique_match: assert property (@(posedge clk) disable iff (rst) $onehot0(match_q))
    else $error("column key matched more than one entry");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst) alloc_en |-> !full)
    else $error("column allocated with table full");

endmodule

/* design/sbm_col_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_col_store
// Column bit memory, one row per column; read, modify one bit, write back.
// ----------------------------------------------------------------------------
module sbm_col_store
  import sbm_pkg::*;
(
  input  logic     clk,
  input  col_req_t req,
  output logic     rd_bit
);

  logic [COLUMN_BITS-1:0] mem [MAX_COLUMNS];
  logic [COLUMN_BITS-1:0] rdata;
  logic [COLUMN_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
    if (req.wr_en) begin
      mem[req.addr] <= wdata;
    end
  end

  // A fresh column starts cleared.
  always_comb begin
    wdata              = req.alloc ? '0 : rdata;
    wdata[req.bit_sel] = req.bit_val;
  end

  assign rd_bit = rdata[req.bit_sel];

endmodule

/* design/sbm_dense_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_dense_store
// Dense bit array held as rows of words; bit read-modify-write and row wipe.
// ----------------------------------------------------------------------------
module sbm_dense_store
  import sbm_pkg::*;
(
  input  logic       clk,
  input  dense_req_t req,
  output logic       rd_bit
);

  logic [DENSE_WORD-1:0] mem [DENSE_ROWS];
  logic [DENSE_WORD-1:0] rdata;
  logic [DENSE_WORD-1:0] wdata;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.row];
    end
    if (req.wr_en) begin
      mem[req.row] <= wdata;
    end
  end

  always_comb begin
    wdata = rdata;
    wdata[req.bit_sel] = req.bit_val;
    if (req.wipe) begin
      wdata = '0;
    end
  end

  assign rd_bit = rdata[req.bit_sel];

endmodule

/* design/sparse_bit_matrix_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_bit_matrix_table_unit
// Sparse boolean matrix: dense bit array plus keyed columns of bits.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Read and write
// commands pass through S_READ and S_WRITE: the key is compared against all
// column keys at the accept edge, the column and dense memories are read at
// the end of S_READ, and the modified row is written back at the end of
// S_WRITE, which also loads the result. done is high for exactly one cycle
// with read_bit and status; the receiver has no way to stall, so sample them
// on that cycle. A clear command empties the column table at once and then
// wipes the dense array one row per cycle, answering once the last row is
// wiped. After reset the same wipe runs with busy high and no result. The
// cfg channel is always ready; write it only while idle.
// cfg_index 0 is limit_enable (cfg_data[0]), 1 is column_limit (cfg_data).
// ----------------------------------------------------------------------------
module sparse_bit_matrix_table_unit
  import sbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [KEY_W-1:0]     key,
  input  logic [POS_W-1:0]     pos,
  input  logic                 bit_value,
  // result
  output logic                 done,
  output logic                 read_bit,
  output logic [STATUS_W-1:0]  status,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  state_t state;
  state_t state_next;

  logic               accept;
  logic               limit_enable;
  logic [LIMIT_W-1:0] column_limit;

  // captured command
  cmd_t             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [POS_W-1:0] pos_q;
  logic             val_q;

  logic [DENSE_ROW_W-1:0] wipe_row;
  logic                   wipe_last;
  logic                   wipe_report;

  logic                 cam_hit;
  logic [COL_IDX_W-1:0] cam_hit_idx;
  logic [COL_IDX_W-1:0] cam_alloc_idx;
  logic                 cam_full;
  logic                 cam_alloc;

  col_req_t   col_req;
  dense_req_t dense_req;
  logic       col_bit;
  logic       dense_bit;

  // decode of the captured command
  logic             is_dense;
  logic             dense_ok;
  logic [CMP_W-1:0] cap;
  logic [CMP_W-1:0] at;
  logic             in_cap;
  logic             col_wr;
  logic             dense_wr;
  logic             rbit;
  status_t          stat;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign wipe_last = (wipe_row == DENSE_ROW_W'(DENSE_ROWS - 1));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (cmd_t'(cmd) == CMD_CLEAR) ? S_WIPE : S_READ;
        end
      end
      S_READ:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      S_WIPE: begin
        if (wipe_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WIPE;
      wipe_row     <= '0;
      wipe_report  <= 1'b0;
      done         <= 1'b0;
      limit_enable <= 1'b0;
      column_limit <= LIMIT_W'(256);
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept) begin
        wipe_row    <= '0;
        wipe_report <= (cmd_t'(cmd) == CMD_CLEAR);
      end else if (state == S_WIPE) begin
        wipe_row <= wipe_row + DENSE_ROW_W'(1);
      end
      if (state == S_WRITE) begin
        done <= 1'b1;
      end else if (state == S_WIPE && wipe_last) begin
        done <= wipe_report;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LIMIT_EN) begin
          limit_enable <= cfg_data[0];
        end else if (cfg_index == REG_COLUMN_LIMIT) begin
          column_limit <= cfg_data;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(cmd);
      key_q <= key;
      pos_q <= pos;
      val_q <= bit_value;
    end
    if (state == S_WRITE) begin
      read_bit <= rbit;
      status   <= stat;
    end else if (state == S_WIPE) begin
      read_bit <= 1'b0;
      status   <= STAT_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  assign is_dense = (pos_q == '0);
  assign dense_ok = (key_q < KEY_W'(DENSE_BITS));
  assign cap      = (limit_enable && (CMP_W'(column_limit) < CMP_W'(COLUMN_BITS)))
                    ? CMP_W'(column_limit) : CMP_W'(COLUMN_BITS);
  assign at       = CMP_W'(pos_q) - CMP_W'(1);
  assign in_cap   = (at < cap);

  // A write miss in range allocates the next free column, if there is one.
  assign col_wr   = (cmd_q == CMD_WRITE) && !is_dense && in_cap && (cam_hit || !cam_full);
  assign dense_wr = (cmd_q == CMD_WRITE) && is_dense && dense_ok;

  always_comb begin
    rbit = 1'b0;
    stat = STAT_OK;
    if (cmd_q == CMD_READ) begin
      rbit = is_dense ? (dense_ok && dense_bit) : (cam_hit && in_cap && col_bit);
    end else if (cmd_q == CMD_WRITE) begin
      if (is_dense) begin
        stat = dense_ok ? STAT_OK : STAT_RANGE;
      end else if (!in_cap) begin
        stat = STAT_RANGE;
      end else if (!cam_hit && cam_full) begin
        stat = STAT_FULL;
      end
    end
  end

  assign cam_alloc = (state == S_WRITE) && col_wr && !cam_hit;

  always_comb begin
    col_req.rd_en   = (state == S_READ);
    col_req.wr_en   = (state == S_WRITE) && col_wr;
    col_req.alloc   = !cam_hit;
    col_req.addr    = cam_hit ? cam_hit_idx : cam_alloc_idx;
    col_req.bit_sel = at[BIT_IDX_W-1:0];
    col_req.bit_val = val_q;
  end

  always_comb begin
    dense_req.rd_en   = (state == S_READ);
    dense_req.wipe    = (state == S_WIPE);
    dense_req.wr_en   = (state == S_WIPE) || ((state == S_WRITE) && dense_wr);
    dense_req.row     = (state == S_WIPE) ? wipe_row : key_q[DENSE_IDX_W-1:DENSE_BIT_W];
    dense_req.bit_sel = key_q[DENSE_BIT_W-1:0];
    dense_req.bit_val = val_q;
  end

  // --------------------------------------------------------------------------
  // Units
  // --------------------------------------------------------------------------
  sbm_key_cam u_cam (
    .clk        (clk),
    .rst        (rst),
    .lookup_en  (accept),
    .lookup_key (key),
    .clear      (accept && (cmd_t'(cmd) == CMD_CLEAR)),
    .alloc_en   (cam_alloc),
    .alloc_key  (key_q),
    .hit        (cam_hit),
    .hit_idx    (cam_hit_idx),
    .alloc_idx  (cam_alloc_idx),
    .full       (cam_full)
  );

  sbm_col_store u_col (
    .clk    (clk),
    .req    (col_req),
    .rd_bit (col_bit)
  );

  sbm_dense_store u_dense (
    .clk    (clk),
    .req    (dense_req),
    .rd_bit (dense_bit)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("command taken but unit not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

/* verif/tb_sparse_bit_matrix_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_bit_matrix_table_unit
// Self-checking bench for the sparse bit matrix unit. A directed table walks
// the edge cases, then a random command stream runs under several column
// limit settings. Each result is checked against the answer in its directed
// row or against an in-bench model of the dense array and keyed column table.
// ----------------------------------------------------------------------------
module tb_sparse_bit_matrix_table_unit;
  import sbm_pkg::*;

  // cmd code the block does not define; it must answer 0 / ok and do nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int N_RANDOM = 1024;
  localparam int N_PHASES = 8;
  localparam int POOL     = 96;   // keys per phase, more than MAX_COLUMNS
  localparam int N_ROWS   = 30;

  // ---------------------------------------------------------------- DUT I/O
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     cmd       = CMD_READ;
  logic [KEY_W-1:0]     key       = '0;
  logic [POS_W-1:0]     pos       = '0;
  logic                 bit_value = 1'b0;
  logic                 done;
  logic                 read_bit;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LIMIT_EN;
  logic [LIMIT_W-1:0]   cfg_data  = '0;

  sparse_bit_matrix_table_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .key       (key),
    .pos       (pos),
    .bit_value (bit_value),
    .done      (done),
    .read_bit  (read_bit),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ------------------------------------------------------------ result type
  typedef struct packed {
    logic                rb;
    logic [STATUS_W-1:0] st;
  } answer_t;

  answer_t answers_due[$];   // one entry per accepted item, oldest first

  int unsigned errors   = 0;
  int unsigned checked  = 0;
  int unsigned n_items  = 0;
  int unsigned n_clears = 0;
  int unsigned n_full   = 0;
  int unsigned n_range  = 0;
  bit          quiet    = 1'b0;   // no sender idling while set

  // -------------------------------------------------------- matrix shadow
  bit                     dense_mem [DENSE_BITS];
  logic [KEY_W-1:0]       col_key   [MAX_COLUMNS];
  bit                     col_live  [MAX_COLUMNS];
  logic [COLUMN_BITS-1:0] col_mem   [MAX_COLUMNS];
  int unsigned            cols_taken = 0;
  bit                     lim_en     = 1'b0;
  logic [LIMIT_W-1:0]     lim_len    = 9'd256;

  // usable bits per column under the current limit registers
  function automatic int unsigned col_capacity();
    if (lim_en && lim_len < COLUMN_BITS) return lim_len;
    return COLUMN_BITS;
  endfunction

  function automatic int find_col(logic [KEY_W-1:0] k);
    for (int i = 0; i < MAX_COLUMNS; i++)
      if (col_live[i] && col_key[i] == k) return i;
    return -1;
  endfunction

  // Apply one command to the shadow and return the answer it must give.
  function automatic answer_t apply_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                            logic [POS_W-1:0] p, logic v);
    answer_t     a;
    int          slot;
    int unsigned at;
    a = '0;
    at = (p == 0) ? 0 : int'(p) - 1;
    case (c)
      CMD_CLEAR: begin
        for (int i = 0; i < DENSE_BITS; i++) dense_mem[i] = 1'b0;
        for (int i = 0; i < MAX_COLUMNS; i++) col_live[i] = 1'b0;
        cols_taken = 0;
      end
      CMD_READ: begin
        if (p == 0) begin
          if (k < DENSE_BITS) a.rb = dense_mem[k];
        end else begin
          slot = find_col(k);
          if (slot >= 0 && at < col_capacity()) a.rb = col_mem[slot][at];
        end
      end
      CMD_WRITE: begin
        if (p == 0) begin
          if (k < DENSE_BITS) dense_mem[k] = v;
          else a.st = STAT_RANGE;
        end else if (at >= col_capacity()) begin
          a.st = STAT_RANGE;
        end else begin
          slot = find_col(k);
          // unknown key: take the next free column, cleared, even for a 0 write
          if (slot < 0) begin
            if (cols_taken >= MAX_COLUMNS) begin
              a.st = STAT_FULL;
            end else begin
              slot = cols_taken;
              cols_taken++;
              col_live[slot] = 1'b1;
              col_key[slot]  = k;
              col_mem[slot]  = '0;
            end
          end
          if (slot >= 0) col_mem[slot][at] = v;
        end
      end
      default: ;   // unused code: no effect
    endcase
    return a;
  endfunction

  // ------------------------------------------------------------- driving
  function automatic int unsigned pick_gap();
    if (quiet) return 0;
    if ($urandom_range(99) < 17) return $urandom_range(1, 6);
    return 0;
  endfunction

  // Issue one item and queue its answer. start stays high on return so a
  // back-to-back item can follow without a dip; whoever goes idle drops it.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [POS_W-1:0] p, input logic v,
                           input bit typed, input answer_t want);
    answer_t     model_ans;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    key       <= k;
    pos       <= p;
    bit_value <= v;
    do @(posedge clk); while (busy);
    // accepted at this edge
    model_ans = apply_command(c, k, p, v);
    if (typed) model_ans = want;
    answers_due.push_back(model_ans);
    n_items++;
    if (c == CMD_CLEAR) n_clears++;
    if (model_ans.st == STAT_FULL) n_full++;
    if (model_ans.st == STAT_RANGE) n_range++;
  endtask

  // Register write, only once the block has drained and gone idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    start <= 1'b0;
    while (answers_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LIMIT_EN) lim_en = data[0];
    else lim_len = data;
  endtask

  // ------------------------------------------------------------- checking
  // done is a one-cycle strobe; the value seen at the edge is the result.
  always @(posedge clk) begin
    answer_t due;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with no item outstanding: read_bit=%0b status=%0d",
                 $time, read_bit, status);
        errors++;
      end else begin
        due = answers_due.pop_front();
        checked++;
        if (read_bit !== due.rb) begin
          $display("%0t: read_bit mismatch: expected %0b, got %0b", $time, due.rb, read_bit);
          errors++;
        end
        if (status !== due.st) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, due.st, status);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------ directed table
  // Register rows reuse the key field for the register index and pos for the
  // data. chk rows carry their answer; the rest go through the shadow.
  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CMD_W-1:0]    c;
    logic [KEY_W-1:0]    k;
    logic [POS_W-1:0]    p;
    logic                v;
    logic                chk;
    logic                rb;
    logic [STATUS_W-1:0] st;
  } row_t;

  row_t plan [N_ROWS] = '{
    // dense array, reset contents and both ends of the index
    '{ROW_CMD, CMD_READ,   32'd0,          9'd0,   1'b0, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'd1023,       9'd0,   1'b0, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_WRITE,  32'd1023,       9'd0,   1'b1, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'd1023,       9'd0,   1'b0, 1'b1, 1'b1, STAT_OK},
    // dense index past the array: error on write, silent 0 on read
    '{ROW_CMD, CMD_WRITE,  32'd1024,       9'd0,   1'b1, 1'b1, 1'b0, STAT_RANGE},
    '{ROW_CMD, CMD_WRITE,  32'hFFFF_FFFF,  9'd0,   1'b1, 1'b1, 1'b0, STAT_RANGE},
    '{ROW_CMD, CMD_READ,   32'hFFFF_FFFF,  9'd0,   1'b0, 1'b1, 1'b0, STAT_OK},
    // unknown column key reads 0
    '{ROW_CMD, CMD_READ,   32'd0,          9'd1,   1'b0, 1'b1, 1'b0, STAT_OK},
    // last bit of a column, top key
    '{ROW_CMD, CMD_WRITE,  32'hFFFF_FFFF,  9'd256, 1'b1, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'hFFFF_FFFF,  9'd256, 1'b0, 1'b0, 1'b0, STAT_OK},
    // zero write still allocates
    '{ROW_CMD, CMD_WRITE,  32'd0,          9'd1,   1'b0, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'd0,          9'd1,   1'b0, 1'b0, 1'b0, STAT_OK},
    // positions beyond the column
    '{ROW_CMD, CMD_WRITE,  32'd5,          9'd257, 1'b1, 1'b1, 1'b0, STAT_RANGE},
    '{ROW_CMD, CMD_WRITE,  32'd5,          9'd511, 1'b1, 1'b1, 1'b0, STAT_RANGE},
    '{ROW_CMD, CMD_READ,   32'hFFFF_FFFF,  9'd511, 1'b0, 1'b1, 1'b0, STAT_OK},
    // unused command code
    '{ROW_CMD, CMD_UNUSED, 32'd7,          9'd3,   1'b1, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_WRITE,  32'd0,          9'd128, 1'b1, 1'b0, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'd0,          9'd128, 1'b0, 1'b0, 1'b0, STAT_OK},
    // clear empties columns and dense array
    '{ROW_CMD, CMD_CLEAR,  32'hA5A5_A5A5,  9'd0,   1'b0, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'hFFFF_FFFF,  9'd256, 1'b0, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'd1023,       9'd0,   1'b0, 1'b1, 1'b0, STAT_OK},
    // lowered limit hides bits that are already set
    '{ROW_CMD, CMD_WRITE,  32'h1234,       9'd200, 1'b1, 1'b1, 1'b0, STAT_OK},
    '{ROW_CFG, CMD_READ,   32'(REG_LIMIT_EN),     9'd1,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{ROW_CFG, CMD_READ,   32'(REG_COLUMN_LIMIT), 9'd100, 1'b0, 1'b0, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'h1234,       9'd200, 1'b0, 1'b1, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_WRITE,  32'h1234,       9'd101, 1'b1, 1'b1, 1'b0, STAT_RANGE},
    // limit of zero: no usable bit
    '{ROW_CFG, CMD_READ,   32'(REG_COLUMN_LIMIT), 9'd0,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_WRITE,  32'h1234,       9'd1,   1'b1, 1'b1, 1'b0, STAT_RANGE},
    // limit off again: the hidden bit comes back, no clear in between
    '{ROW_CFG, CMD_READ,   32'(REG_LIMIT_EN),     9'd0,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{ROW_CMD, CMD_READ,   32'h1234,       9'd200, 1'b0, 1'b0, 1'b0, STAT_OK}
  };

  // ------------------------------------------------------- random settings
  // limit_enable / column_limit per phase; odd phases never clear so the
  // column table runs full.
  bit                 phase_en  [N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  logic [LIMIT_W-1:0] phase_len [N_PHASES] = '{9'd256, 9'd1, 9'd256, 9'd37,
                                               9'd511, 9'd300, 9'd200, 9'd8};

  initial begin
    answer_t          want;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] p;
    logic             v;
    logic [KEY_W-1:0] pool_seed;
    int unsigned      r;
    int unsigned      cap;
    int unsigned      clear_pct;

    for (int i = 0; i < DENSE_BITS; i++) dense_mem[i] = 1'b0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      col_live[i] = 1'b0;
      col_key[i]  = '0;
      col_mem[i]  = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part; send_item waits out the post-reset wipe through busy
    for (int i = 0; i < N_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].k[CFG_IDX_W-1:0], plan[i].p);
      end else begin
        want.rb = plan[i].rb;
        want.st = plan[i].st;
        send_item(plan[i].c, plan[i].k, plan[i].p, plan[i].v, plan[i].chk, want);
      end
    end

    // random part
    want = '0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_LIMIT_EN, {8'($urandom), phase_en[ph]});
      write_reg(REG_COLUMN_LIMIT, phase_len[ph]);
      quiet     = (ph == 2);
      clear_pct = ph[0] ? 0 : 4;
      pool_seed = $urandom();
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
        r = $urandom_range(99);
        k = $urandom();
        p = 9'($urandom());
        v = 1'($urandom());
        if (r < clear_pct) begin
          c = CMD_CLEAR;
        end else if (r < clear_pct + 2) begin
          c = CMD_UNUSED;
        end else begin
          c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
          r = $urandom_range(99);
          if (r < 30) begin
            // dense array, mostly in range
            p = '0;
            r = $urandom_range(99);
            if (r < 50) k = $urandom_range(63);
            else if (r < 90) k = $urandom_range(DENSE_BITS - 1);
            else if (r < 95) k = $urandom_range(DENSE_BITS, 2 * DENSE_BITS - 1);
          end else begin
            // column access: keys from a pool so reads hit written columns
            if ($urandom_range(99) < 95)
              k = pool_seed ^ (32'($urandom_range(POOL - 1)) * 32'h9E37_79B1);
            cap = col_capacity();
            r = $urandom_range(99);
            if (r < 85) p = $urandom_range(1, (cap == 0) ? 1 : cap);
            else if (r < 95) p = $urandom_range(1, COLUMN_BITS);
            else p = $urandom_range(COLUMN_BITS + 1, 511);
          end
        end
        send_item(c, k, p, v, 1'b0, want);
      end
    end

    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d commands (%0d directed rows) over %0d limit settings, %0d results checked.",
             n_items, N_ROWS, N_PHASES, checked);
    $display("Exercised %0d clears, %0d table-full and %0d out-of-range answers, %0d errors.",
             n_clears, n_full, n_range, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
